// ===== sv/mrs_pkg.sv =====
// Shared types, constants and the CRC step for the Modbus RTU slave responder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

	localparam int REG_COUNT_DEF       = 16;
	localparam int MAX_FRAME_BYTES_DEF = 64;
	localparam int MIN_FRAME_BYTES     = 8;
	localparam int HDR_BYTES           = 6;
	localparam int CMD_AW              = 5;
	localparam int Q_DEPTH             = 2;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  OWN_ADDR_RESET = 8'h01;

	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_READ_INPUT   = 8'h04;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	localparam logic OP_BUS_BYTE    = 1'b0;
	localparam logic OP_LOCAL_WRITE = 1'b1;
	localparam logic KIND_TX_BYTE   = 1'b0;
	localparam logic KIND_NOTE      = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  rx_byte;
		logic        frame_end;
		logic [3:0]  local_index;
		logic [15:0] local_value;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic [3:0]  note_index;
		logic [15:0] note_value;
		logic        note_write;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LOCAL,
		CMD_READ,
		CMD_WRITE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        fc;
		logic [CMD_AW-1:0] addr;
		logic [15:0]       value;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mrs_front.sv =====
// Receive side: collects frame bytes, CRC, header, and classifies each frame.
// Emits commands for the back end; depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_front #(
	parameter int REG_COUNT       = mrs_pkg::REG_COUNT_DEF,
	parameter int MAX_FRAME_BYTES = mrs_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire mrs_pkg::in_item_t in_data,
	input  wire logic [7:0]       own_address,
	output logic                  cmd_valid,
	output mrs_pkg::cmd_t         cmd,
	input  wire logic             cmd_full
);
	import mrs_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [15:0]      crc_q;
	logic [15:0]      trail_q;
	logic [7:0]       hdr_q [HDR_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             fend_q;
	logic             cmd_vld_q;
	cmd_t             cmd_q;

	logic        acc;
	logic        take_byte;
	logic [15:0] recv;
	logic [15:0] a_w;
	logic [15:0] q_w;
	logic [16:0] span;
	logic        frame_ok;
	logic        is_rd;
	logic        is_wr;
	logic        local_ok;

	assign in_stall  = fend_q || cmd_vld_q;
	assign acc       = in_valid && !in_stall;
	assign take_byte = acc && (in_data.op == OP_BUS_BYTE) && !ovf_q
		&& (cnt_q < CNT_W'(MAX_FRAME_BYTES));

	assign recv     = {trail_q[7:0], trail_q[15:8]};
	assign a_w      = {hdr_q[2], hdr_q[3]};
	assign q_w      = {hdr_q[4], hdr_q[5]};
	assign span     = {1'b0, a_w} + {1'b0, q_w};
	assign frame_ok = !ovf_q && (cnt_q >= CNT_W'(MIN_FRAME_BYTES)) && (recv == crc_q)
		&& (hdr_q[0] == own_address);
	assign is_rd    = ((hdr_q[1] == FC_READ_HOLDING) || (hdr_q[1] == FC_READ_INPUT))
		&& (span <= 17'(REG_COUNT));
	assign is_wr    = (hdr_q[1] == FC_WRITE_SINGLE) && (a_w < 16'(REG_COUNT));
	assign local_ok = {1'b0, in_data.local_index} < 5'(REG_COUNT);

	assign cmd_valid = cmd_vld_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			trail_q   <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			fend_q    <= 1'b0;
			cmd_vld_q <= 1'b0;
			cmd_q     <= '0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else begin
			if (cmd_vld_q && !cmd_full) begin
				cmd_vld_q <= 1'b0;
			end
			if (take_byte) begin
				if (cnt_q < CNT_W'(HDR_BYTES)) begin
					hdr_q[cnt_q[2:0]] <= in_data.rx_byte;
				end
				if (cnt_q >= CNT_W'(2)) begin
					crc_q <= crc_byte(crc_q, trail_q[15:8]);
				end
				trail_q <= {trail_q[7:0], in_data.rx_byte};
				cnt_q   <= cnt_q + CNT_W'(1);
			end else if (acc && (in_data.op == OP_BUS_BYTE)) begin
				ovf_q <= 1'b1;
			end
			if (acc && (in_data.op == OP_BUS_BYTE) && in_data.frame_end) begin
				fend_q <= 1'b1;
			end
			if (acc && (in_data.op == OP_LOCAL_WRITE) && local_ok) begin
				cmd_vld_q   <= 1'b1;
				cmd_q.kind  <= CMD_LOCAL;
				cmd_q.fc    <= '0;
				cmd_q.addr  <= CMD_AW'(in_data.local_index);
				cmd_q.value <= in_data.local_value;
			end
			if (fend_q) begin
				fend_q      <= 1'b0;
				cmd_vld_q   <= frame_ok && (is_rd || is_wr);
				cmd_q.kind  <= is_rd ? CMD_READ : CMD_WRITE;
				cmd_q.fc    <= hdr_q[1];
				cmd_q.addr  <= CMD_AW'(a_w);
				cmd_q.value <= q_w;
				crc_q       <= CRC_INIT;
				trail_q     <= '0;
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				for (int i = 0; i < HDR_BYTES; i++) begin
					hdr_q[i] <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mrs_queue.sv =====
// Short command queue between the receive side and the response sequencer.
// Depends on mrs_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mrs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mrs_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output mrs_pkg::cmd_t      dout,
	output logic               empty
);
	import mrs_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int FILL_W = $clog2(Q_DEPTH + 1);

	cmd_t              mem_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full    = (fill_q == FILL_W'(Q_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mrs_back.sv =====
// Response sequencer: owns the register bank, runs commands from the queue
// and streams notifications and response bytes with CRC. Depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_back #(
	parameter int REG_COUNT = mrs_pkg::REG_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mrs_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire logic [7:0]    own_address,
	output logic               out_valid,
	input  wire logic          out_stall,
	output mrs_pkg::out_item_t out_data
);
	import mrs_pkg::*;

	localparam int BANK_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [2:0] HDR_LAST_RD = 3'd2;
	localparam logic [2:0] HDR_LAST_WR = 3'd5;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RNOTE = 7'b0000010,
		S_WNOTE = 7'b0000100,
		S_HDR   = 7'b0001000,
		S_DATA  = 7'b0010000,
		S_CRCL  = 7'b0100000,
		S_CRCH  = 7'b1000000
	} state_t;

	logic [15:0]       bank_q [REG_COUNT];
	state_t            st_q;
	logic              rd_q;
	logic [7:0]        fc_q;
	logic [CMD_AW-1:0] addr_q;
	logic [15:0]       val_q;
	logic [CMD_AW-1:0] cnt_q;
	logic [2:0]        step_q;
	logic              half_q;
	logic [15:0]       crc_q;
	logic              out_vld_q;
	out_item_t         out_q;

	logic              advance;
	logic [CMD_AW-1:0] ridx;
	logic [CMD_AW-1:0] cnt_inc;
	logic              cnt_done;
	logic [15:0]       rdata;
	out_item_t         item;
	logic [15:0]       crc_next;

	assign advance  = !out_vld_q || !out_stall;
	assign ridx     = addr_q + cnt_q;
	assign cnt_inc  = cnt_q + CMD_AW'(1);
	assign cnt_done = (cnt_inc == val_q[CMD_AW-1:0]);
	assign rdata    = bank_q[ridx[BANK_AW-1:0]];
	assign cmd_pop  = (st_q == S_IDLE) && !cmd_empty;
	assign crc_next = crc_byte(crc_q, item.tx_byte);

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		item      = '0;
		item.kind = KIND_TX_BYTE;
		case (st_q)
			S_RNOTE: begin
				item.kind       = KIND_NOTE;
				item.note_index = 4'(ridx);
				item.note_value = rdata;
			end
			S_WNOTE: begin
				item.kind       = KIND_NOTE;
				item.note_index = 4'(addr_q);
				item.note_value = val_q;
				item.note_write = 1'b1;
			end
			S_HDR: begin
				case (step_q)
					3'd0: item.tx_byte = own_address;
					3'd1: item.tx_byte = fc_q;
					3'd2: item.tx_byte = rd_q ? {val_q[6:0], 1'b0} : 8'h00;
					3'd3: item.tx_byte = 8'(addr_q);
					3'd4: item.tx_byte = val_q[15:8];
					default: item.tx_byte = val_q[7:0];
				endcase
			end
			S_DATA: item.tx_byte = half_q ? rdata[7:0] : rdata[15:8];
			S_CRCL: item.tx_byte = crc_q[7:0];
			S_CRCH: begin
				item.tx_byte = crc_q[15:8];
				item.last    = 1'b1;
			end
			default: item = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			rd_q      <= 1'b0;
			fc_q      <= '0;
			addr_q    <= '0;
			val_q     <= '0;
			cnt_q     <= '0;
			step_q    <= '0;
			half_q    <= 1'b0;
			crc_q     <= CRC_INIT;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			for (int i = 0; i < REG_COUNT; i++) begin
				bank_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				out_vld_q <= (st_q != S_IDLE);
				out_q     <= item;
			end
			case (st_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						rd_q   <= (cmd.kind == CMD_READ);
						fc_q   <= cmd.fc;
						addr_q <= cmd.addr;
						val_q  <= cmd.value;
						cnt_q  <= '0;
						step_q <= '0;
						half_q <= 1'b0;
						crc_q  <= CRC_INIT;
						case (cmd.kind)
							CMD_LOCAL: bank_q[cmd.addr[BANK_AW-1:0]] <= cmd.value;
							CMD_WRITE: begin
								bank_q[cmd.addr[BANK_AW-1:0]] <= cmd.value;
								st_q <= S_WNOTE;
							end
							CMD_READ: st_q <= (cmd.value == '0) ? S_HDR : S_RNOTE;
							default: st_q <= S_IDLE;
						endcase
					end
				end
				S_RNOTE: begin
					if (advance) begin
						if (cnt_done) begin
							cnt_q <= '0;
							st_q  <= S_HDR;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				S_WNOTE: begin
					if (advance) begin
						st_q <= S_HDR;
					end
				end
				S_HDR: begin
					if (advance) begin
						crc_q <= crc_next;
						if (rd_q && (step_q == HDR_LAST_RD)) begin
							cnt_q  <= '0;
							half_q <= 1'b0;
							st_q   <= (val_q == '0) ? S_CRCL : S_DATA;
						end else if (step_q == HDR_LAST_WR) begin
							st_q <= S_CRCL;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				S_DATA: begin
					if (advance) begin
						crc_q  <= crc_next;
						half_q <= !half_q;
						if (half_q) begin
							if (cnt_done) begin
								st_q <= S_CRCL;
							end else begin
								cnt_q <= cnt_inc;
							end
						end
					end
				end
				S_CRCL: begin
					if (advance) begin
						st_q <= S_CRCH;
					end
				end
				S_CRCH: begin
					if (advance) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_slave_responder.sv =====
// Top level of the Modbus RTU slave responder (function codes 3, 4 and 6).
// Instantiates mrs_front, mrs_queue and mrs_back; depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A bus byte that does not end a frame is taken without holding the input. A
// frame-end byte holds the input while the receive side checks the frame, and
// longer when the frame yields a command for the two-entry queue; a local
// register write holds the input while its command enters the queue. A full
// queue holds the input longer. The response sequencer then emits one result
// per cycle when the output is not stalled: q read notifications, then 5 + 2q
// response bytes for a read, or one write notification and 8 bytes for a
// single register write. The last byte of each response carries last.

module modbus_rtu_slave_responder #(
	parameter int REG_COUNT       = mrs_pkg::REG_COUNT_DEF,
	parameter int MAX_FRAME_BYTES = mrs_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire mrs_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output mrs_pkg::out_item_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);
	import mrs_pkg::*;

	logic [7:0] own_q;
	logic       cmd_valid;
	cmd_t       cmd_in;
	cmd_t       cmd_out;
	logic       cmd_full;
	logic       cmd_empty;
	logic       cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= OWN_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			own_q <= cfg_data;
		end
	end

	mrs_front #(
		.REG_COUNT      (REG_COUNT),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.own_address(own_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd_in),
		.cmd_full   (cmd_full)
	);

	mrs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_valid),
		.din   (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (cmd_empty)
	);

	mrs_back #(
		.REG_COUNT(REG_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.own_address(own_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ===== sv/mrs_checker.sv =====
// Port-level checks for modbus_rtu_slave_responder and the bind that attaches them.
// Depends on mrs_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module mrs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire mrs_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire mrs_pkg::out_item_t out_data
);
	import mrs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_fend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.op == OP_BUS_BYTE) && in_data.frame_end
		|=> in_stall)
		else $error("frame end not held for classification");

	a_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.kind == KIND_TX_BYTE)
		else $error("last set on a notification");

	a_note_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_NOTE) |-> out_data.tx_byte == 8'h00)
		else $error("notification carries a tx byte");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_TX_BYTE)
		|-> (out_data.note_value == 16'h0000) && (out_data.note_index == 4'h0)
		&& !out_data.note_write)
		else $error("response byte carries note fields");

endmodule

bind modbus_rtu_slave_responder mrs_checker u_mrs_checker (.*);

`default_nettype wire
